// ===== sv/stsu_pkg.sv =====
// shared types and constants of the sphere triangle subdivider
`default_nettype none
package stsu_pkg;
  localparam int COORD_W   = 16;
  localparam int FRAC_BITS = 14;
  localparam int MAX_DEPTH = 3;
  localparam int LVL_W     = 2;
  localparam int NUM_LVL   = MAX_DEPTH + 1;
  localparam int SUM_W     = COORD_W + 1;
  localparam int MAG_W     = COORD_W + 1;
  localparam int SQ_W      = 2 * MAG_W - 1;
  localparam int LEN2_W    = SQ_W + 2;
  localparam int SRCH_W    = FRAC_BITS + 1;
  localparam int DD_W      = 2 * SRCH_W;
  localparam int MUL_W     = 32;
  localparam int PROD_W    = 64;
  localparam int TGT_SH    = 2 * FRAC_BITS + 2;

  localparam logic [0:0] REG_DEPTH = 1'b0;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t z;
  } vtx_t;
  typedef struct packed {
    vtx_t a;
    vtx_t b;
    vtx_t c;
  } tri_t;
endpackage
`default_nettype wire

// ===== sv/sphere_triangle_subdivider_unit.sv =====
// top level: depth-first subdivision sequencer, result register and config port
// one input triangle yields 4^depth leaves; a midpoint squares its three coordinate sums and then
// runs up to 15 bisection steps per coordinate (N_IT, N_M1, N_M2, N_CMP), all through the one multiplier
// a leaf is loaded into the result register from T_DESC after its last midpoint
// in_ready is high only between items; the next item is taken after the last leaf transfer
// synchronous active-low reset clears the sequencer, result valid and depth (to 0)
`default_nettype none
module sphere_triangle_subdivider_unit import stsu_pkg::*; (
  input  wire  logic        clk,
  input  wire  logic        rst_n,
  input  wire  logic        psel,
  input  wire  logic        penable,
  input  wire  logic        pwrite,
  input  wire  logic [2:0]  paddr,
  input  wire  logic [31:0] pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  input  wire  logic        in_valid,
  output logic              in_ready,
  input  wire  coord_t      in_v1_x,
  input  wire  coord_t      in_v1_y,
  input  wire  coord_t      in_v1_z,
  input  wire  coord_t      in_v2_x,
  input  wire  coord_t      in_v2_y,
  input  wire  coord_t      in_v2_z,
  input  wire  coord_t      in_v3_x,
  input  wire  coord_t      in_v3_y,
  input  wire  coord_t      in_v3_z,
  output logic              out_valid,
  input  wire  logic        out_ready,
  output coord_t            out_a_x,
  output coord_t            out_a_y,
  output coord_t            out_a_z,
  output coord_t            out_b_x,
  output coord_t            out_b_y,
  output coord_t            out_b_z,
  output coord_t            out_c_x,
  output coord_t            out_c_y,
  output coord_t            out_c_z,
  output logic              out_last_of_run
);
  localparam logic [2:0] T_IDLE   = 3'd0;
  localparam logic [2:0] T_DESC   = 3'd1;
  localparam logic [2:0] T_MSTART = 3'd2;
  localparam logic [2:0] T_MWAIT  = 3'd3;
  localparam logic [2:0] T_OUT    = 3'd4;
  localparam logic [2:0] T_POP    = 3'd5;

  function automatic tri_t child_tri(tri_t t, vtx_t ab, vtx_t bc, vtx_t ca,
                                     logic [1:0] k);
    tri_t c;
    unique case (k)
      2'd0: c = '{a: t.a, b: ab, c: ca};
      2'd1: c = '{a: t.b, b: bc, c: ab};
      2'd2: c = '{a: t.c, b: ca, c: bc};
      2'd3: c = '{a: ab, b: bc, c: ca};
      default: c = t;
    endcase
    return c;
  endfunction

  logic [2:0]       state_r;
  logic [LVL_W-1:0] lvl_r;
  logic [1:0]       m_r;
  logic [1:0]       child_r [MAX_DEPTH];
  logic [LVL_W-1:0] depth_r, use_r;
  tri_t             tri_r [NUM_LVL];
  vtx_t             mid_r [MAX_DEPTH][3];
  tri_t             out_tri_r;
  logic             out_valid_r, out_last_r;

  // per-level view of the triangle and its midpoints
  tri_t             cur;
  logic [LVL_W-1:0] par;
  logic [1:0]       par_k;
  vtx_t             np, nq, nr;
  logic             n_start, n_done;
  logic             leaf_last;
  logic             cfg_wr;

  // config port: one register, depth
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_DEPTH);
  assign prdata = (paddr[2] == REG_DEPTH) ? {30'b0, depth_r} : 32'b0;

  always_comb begin
    cur   = tri_r[lvl_r];
    par   = lvl_r - LVL_W'(1);
    par_k = child_r[par] + 2'd1;
    unique case (m_r)
      2'd0: begin np = cur.a; nq = cur.b; end
      2'd1: begin np = cur.b; nq = cur.c; end
      default: begin np = cur.c; nq = cur.a; end
    endcase
    // last leaf when every ancestor sits on its fourth child
    leaf_last = 1'b1;
    for (int j = 0; j < MAX_DEPTH; j++) begin
      if ((LVL_W'(j) < lvl_r) && (child_r[j] != 2'd3)) leaf_last = 1'b0;
    end
  end

  assign n_start = (state_r == T_MSTART);

  stsu_norm u_norm (
    .clk(clk), .rst_n(rst_n), .start(n_start), .p(np), .q(nq),
    .done_r(n_done), .r(nr)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= T_IDLE;
      lvl_r       <= '0;
      m_r         <= '0;
      depth_r     <= '0;
      use_r       <= '0;
      out_valid_r <= 1'b0;
      for (int j = 0; j < MAX_DEPTH; j++) child_r[j] <= '0;
    end else begin
      if (cfg_wr) depth_r <= pwdata[LVL_W-1:0];
      unique case (state_r)
        T_IDLE: begin
          if (in_valid) begin
            tri_r[0] <= '{a: '{x: in_v1_x, y: in_v1_y, z: in_v1_z},
                          b: '{x: in_v2_x, y: in_v2_y, z: in_v2_z},
                          c: '{x: in_v3_x, y: in_v3_y, z: in_v3_z}};
            use_r    <= (32'(depth_r) > MAX_DEPTH) ? LVL_W'(MAX_DEPTH) : depth_r;
            lvl_r    <= '0;
            for (int j = 0; j < MAX_DEPTH; j++) child_r[j] <= '0;
            state_r  <= T_DESC;
          end
        end
        T_DESC: begin
          if (lvl_r >= use_r) begin
            out_tri_r   <= cur;
            out_last_r  <= leaf_last;
            out_valid_r <= 1'b1;
            state_r     <= T_OUT;
          end else begin
            m_r     <= 2'd0;
            state_r <= T_MSTART;
          end
        end
        T_MSTART: state_r <= T_MWAIT;
        T_MWAIT: begin
          if (n_done) begin
            mid_r[lvl_r][m_r] <= nr;
            if (m_r == 2'd2) begin
              // all three midpoints ready: push the first child
              tri_r[lvl_r + LVL_W'(1)] <= child_tri(cur, mid_r[lvl_r][0],
                                                    mid_r[lvl_r][1], nr, 2'd0);
              child_r[lvl_r] <= 2'd0;
              lvl_r          <= lvl_r + LVL_W'(1);
              state_r        <= T_DESC;
            end else begin
              m_r     <= m_r + 2'd1;
              state_r <= T_MSTART;
            end
          end
        end
        T_OUT: begin
          if (out_ready) begin
            out_valid_r <= 1'b0;
            state_r     <= T_POP;
          end
        end
        T_POP: begin
          if (lvl_r == '0) begin
            state_r <= T_IDLE;
          end else if (child_r[par] == 2'd3) begin
            lvl_r <= par;
          end else begin
            // next sibling replaces the current level
            child_r[par] <= par_k;
            tri_r[lvl_r] <= child_tri(tri_r[par], mid_r[par][0], mid_r[par][1],
                                      mid_r[par][2], par_k);
            state_r      <= T_DESC;
          end
        end
        default: state_r <= T_IDLE;
      endcase
    end
  end

  assign in_ready        = (state_r == T_IDLE);
  assign out_valid       = out_valid_r;
  assign out_a_x         = out_tri_r.a.x;
  assign out_a_y         = out_tri_r.a.y;
  assign out_a_z         = out_tri_r.a.z;
  assign out_b_x         = out_tri_r.b.x;
  assign out_b_y         = out_tri_r.b.y;
  assign out_b_z         = out_tri_r.b.z;
  assign out_c_x         = out_tri_r.c.x;
  assign out_c_y         = out_tri_r.c.y;
  assign out_c_z         = out_tri_r.c.z;
  assign out_last_of_run = out_last_r;
endmodule
`default_nettype wire

// ===== sv/stsu_mul.sv =====
// shared unsigned multiplier with registered product
`default_nettype none
module stsu_mul import stsu_pkg::*; (
  input  logic              clk,
  input  logic [MUL_W-1:0]  a,
  input  logic [MUL_W-1:0]  b,
  output logic [PROD_W-1:0] p_r
);
  always_ff @(posedge clk) begin
    p_r <= a * b;
  end
endmodule
`default_nettype wire

// ===== sv/stsu_norm.sv =====
// edge midpoint normalizer: bisection search driven through the shared multiplier
`default_nettype none
module stsu_norm import stsu_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  input  vtx_t p,
  input  vtx_t q,
  output logic done_r,
  output vtx_t r
);
  localparam logic [3:0] N_IDLE = 4'd0;
  localparam logic [3:0] N_SQ0  = 4'd1;
  localparam logic [3:0] N_SQ1  = 4'd2;
  localparam logic [3:0] N_SQ2  = 4'd3;
  localparam logic [3:0] N_SUM  = 4'd4;
  localparam logic [3:0] N_IT   = 4'd5;
  localparam logic [3:0] N_M1   = 4'd6;
  localparam logic [3:0] N_M2   = 4'd7;
  localparam logic [3:0] N_CMP  = 4'd8;

  localparam logic [SRCH_W-1:0] ONE = SRCH_W'(1) << FRAC_BITS;

  logic [3:0]              state_r;
  logic signed [SUM_W-1:0] s_r [3];
  logic [SQ_W-1:0]         sq_r [3];
  logic [LEN2_W-1:0]       len2_r;
  logic [1:0]              idx_r;
  logic [SRCH_W-1:0]       lo_r, hi_r, mid_r;
  logic [DD_W-1:0]         dd_r;
  logic [PROD_W-1:0]       pl_r;
  coord_t                  rc_r [3];

  logic [MAG_W-1:0]  mag [3];
  logic [SRCH_W:0]   mid_sum;
  logic [SRCH_W-1:0] mid_c;
  logic [SRCH_W-1:0] d_c;
  logic [MUL_W-1:0]  mul_a, mul_b;
  logic [PROD_W-1:0] mul_p;
  logic [PROD_W-1:0] prod_c, tgt_c;
  logic [LEN2_W-1:0] len2_c;
  coord_t            lo_s;

  stsu_mul u_mul (.clk(clk), .a(mul_a), .b(mul_b), .p_r(mul_p));

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      mag[i] = s_r[i][SUM_W-1] ? MAG_W'(-s_r[i]) : MAG_W'(s_r[i]);
    end
    mid_sum = {1'b0, lo_r} + {1'b0, hi_r} + (SRCH_W+1)'(1);
    mid_c   = mid_sum[SRCH_W:1];
    d_c     = SRCH_W'({mid_c, 1'b0} - (SRCH_W+1)'(1));
    prod_c  = pl_r + {mul_p[31:0], 32'b0};
    tgt_c   = PROD_W'(sq_r[idx_r]) << TGT_SH;
    len2_c  = LEN2_W'(sq_r[0]) + LEN2_W'(sq_r[1]) + LEN2_W'(mul_p[SQ_W-1:0]);
    lo_s    = s_r[idx_r][SUM_W-1] ? -COORD_W'(lo_r) : COORD_W'(lo_r);
    mul_a   = '0;
    mul_b   = '0;
    unique case (state_r)
      N_SQ0: begin mul_a = MUL_W'(mag[0]); mul_b = MUL_W'(mag[0]); end
      N_SQ1: begin mul_a = MUL_W'(mag[1]); mul_b = MUL_W'(mag[1]); end
      N_SQ2: begin mul_a = MUL_W'(mag[2]); mul_b = MUL_W'(mag[2]); end
      N_IT: begin mul_a = MUL_W'(d_c); mul_b = MUL_W'(d_c); end
      N_M1: begin
        mul_a = MUL_W'(mul_p[DD_W-1:0]);
        mul_b = len2_r[31:0];
      end
      N_M2: begin
        mul_a = MUL_W'(dd_r);
        mul_b = MUL_W'(len2_r[LEN2_W-1:32]);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= N_IDLE;
      done_r  <= 1'b0;
    end else begin
      done_r <= 1'b0;
      unique case (state_r)
        N_IDLE: begin
          if (start) begin
            s_r[0]  <= SUM_W'(p.x) + SUM_W'(q.x);
            s_r[1]  <= SUM_W'(p.y) + SUM_W'(q.y);
            s_r[2]  <= SUM_W'(p.z) + SUM_W'(q.z);
            state_r <= N_SQ0;
          end
        end
        N_SQ0: state_r <= N_SQ1;
        N_SQ1: begin
          sq_r[0] <= mul_p[SQ_W-1:0];
          state_r <= N_SQ2;
        end
        N_SQ2: begin
          sq_r[1] <= mul_p[SQ_W-1:0];
          state_r <= N_SUM;
        end
        N_SUM: begin
          sq_r[2] <= mul_p[SQ_W-1:0];
          len2_r  <= len2_c;
          idx_r   <= 2'd0;
          lo_r    <= '0;
          hi_r    <= ONE;
          if (len2_c == '0) begin
            // opposite endpoints give the zero vector
            for (int i = 0; i < 3; i++) rc_r[i] <= '0;
            done_r  <= 1'b1;
            state_r <= N_IDLE;
          end else begin
            state_r <= N_IT;
          end
        end
        N_IT: begin
          if (lo_r == hi_r) begin
            rc_r[idx_r] <= lo_s;
            lo_r        <= '0;
            hi_r        <= ONE;
            if (idx_r == 2'd2) begin
              done_r  <= 1'b1;
              state_r <= N_IDLE;
            end else begin
              idx_r <= idx_r + 2'd1;
            end
          end else begin
            mid_r   <= mid_c;
            state_r <= N_M1;
          end
        end
        N_M1: begin
          dd_r    <= mul_p[DD_W-1:0];
          state_r <= N_M2;
        end
        N_M2: begin
          pl_r    <= mul_p;
          state_r <= N_CMP;
        end
        N_CMP: begin
          if (prod_c <= tgt_c) lo_r <= mid_r;
          else                 hi_r <= mid_r - SRCH_W'(1);
          state_r <= N_IT;
        end
        default: state_r <= N_IDLE;
      endcase
    end
  end

  assign r = '{x: rc_r[0], y: rc_r[1], z: rc_r[2]};
endmodule
`default_nettype wire
